// ===== src/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants for the cosine similarity matcher
// Element and accumulator widths, queue sizing, score limits and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

  // Nominal vector length; the accumulators are sized so that it fits exactly
  localparam int VECTOR_LENGTH = 512;

  // Q1.15 element width
  localparam int ELEM_W = 16;

  // Squared element magnitude is at most 2^30, so 31 bits
  localparam int SQ_W = 2 * ELEM_W - 1;

  // Running sums: squared width plus growth over the vector
  localparam int ACC_W = SQ_W + $clog2(VECTOR_LENGTH);

  // Operand halves for the shared multiplier in the back end
  localparam int HALF_W = (ACC_W + 1) / 2;

  // Full product of two accumulators
  localparam int PROD_W = 2 * ACC_W;

  // Score magnitude bits searched one at a time
  localparam int QBITS = ELEM_W;

  // Signed width of the search datapath (energy product times odd square)
  localparam int SRCH_W = PROD_W + 2 * QBITS + 4;

  // Queue between front and back end
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Score limits in Q1.15
  localparam logic [ELEM_W-1:0] SCORE_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SCORE_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // Threshold after reset: 0.40 in Q1.15
  localparam logic signed [ELEM_W-1:0] THR_RESET = 16'sd13107;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = '0;

  // Finished sums of one vector, handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic        [ACC_W-1:0] ref_energy;
    logic        [ACC_W-1:0] prb_energy;
  } csm_sums_t;

endpackage

`default_nettype wire

// ===== src/csm_if.sv =====
// ----------------------------------------------------------------------------
// csm_if: valid/ready channel interfaces
// Input channel carries one element pair, result channel one score.
// ----------------------------------------------------------------------------
`default_nettype none

interface csm_in_if import csm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] reference_element;
  logic signed [ELEM_W-1:0] probe_element;
  logic                     last_element;

  modport source (
    output valid, reference_element, probe_element, last_element,
    input  ready
  );
  modport sink (
    input  valid, reference_element, probe_element, last_element,
    output ready
  );
endinterface

interface csm_out_if import csm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] similarity;
  logic                     is_match;

  modport source (
    output valid, similarity, is_match,
    input  ready
  );
  modport sink (
    input  valid, similarity, is_match,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/csm_front.sv =====
// ----------------------------------------------------------------------------
// csm_front: element accumulator
// Registers the three element products, then adds them into saturating
// running sums. On the last element it pushes the sums and clears them.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_front import csm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  csm_in_if.sink                 in_chan,
  input  wire logic [QCNT_W-1:0] q_cnt,
  output logic                   push_vld,
  output csm_sums_t              push_data
);

  localparam logic [ACC_W-1:0] DOT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] DOT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                       s1_vld_r;
  logic                       s1_last_r;
  logic signed [2*ELEM_W-1:0] s1_dot_r;
  logic        [SQ_W-1:0]     s1_ref_sq_r;
  logic        [SQ_W-1:0]     s1_prb_sq_r;

  logic signed [ACC_W-1:0]    dot_sum_r;
  logic        [ACC_W-1:0]    ref_energy_r;
  logic        [ACC_W-1:0]    prb_energy_r;

  logic signed [2*ELEM_W-1:0] ref_sq_full;
  logic signed [2*ELEM_W-1:0] prb_sq_full;
  logic        [ACC_W:0]      dot_ext;
  logic        [ACC_W:0]      ref_ext;
  logic        [ACC_W:0]      prb_ext;
  logic        [ACC_W-1:0]    dot_nxt;
  logic        [ACC_W-1:0]    ref_nxt;
  logic        [ACC_W-1:0]    prb_nxt;
  logic        [QCNT_W:0]     q_need;
  logic                       accept;

  // Keep a free queue slot for every vector end that may still arrive
  assign q_need        = (QCNT_W+1)'(q_cnt) + (QCNT_W+1)'(s1_vld_r & s1_last_r);
  assign in_chan.ready = (q_need < (QCNT_W+1)'(QDEPTH));
  assign accept        = in_chan.valid & in_chan.ready;

  assign ref_sq_full = in_chan.reference_element * in_chan.reference_element;
  assign prb_sq_full = in_chan.probe_element * in_chan.probe_element;

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    if (accept) begin
      s1_last_r   <= in_chan.last_element;
      s1_dot_r    <= in_chan.reference_element * in_chan.probe_element;
      s1_ref_sq_r <= ref_sq_full[SQ_W-1:0];
      s1_prb_sq_r <= prb_sq_full[SQ_W-1:0];
    end
  end

  // Saturating sums
  always_comb begin
    dot_ext = (ACC_W+1)'(dot_sum_r) + (ACC_W+1)'(s1_dot_r);
    ref_ext = {1'b0, ref_energy_r} + (ACC_W+1)'(s1_ref_sq_r);
    prb_ext = {1'b0, prb_energy_r} + (ACC_W+1)'(s1_prb_sq_r);

    if (dot_ext[ACC_W] != dot_ext[ACC_W-1]) begin
      dot_nxt = dot_ext[ACC_W] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_nxt = dot_ext[ACC_W-1:0];
    end
    ref_nxt = ref_ext[ACC_W] ? {ACC_W{1'b1}} : ref_ext[ACC_W-1:0];
    prb_nxt = prb_ext[ACC_W] ? {ACC_W{1'b1}} : prb_ext[ACC_W-1:0];
  end

  assign push_vld             = s1_vld_r & s1_last_r;
  assign push_data.dot        = dot_nxt;
  assign push_data.ref_energy = ref_nxt;
  assign push_data.prb_energy = prb_nxt;

  // Advance the sums; clear them once a vector is pushed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_sum_r    <= '0;
      ref_energy_r <= '0;
      prb_energy_r <= '0;
    end else if (s1_vld_r) begin
      if (s1_last_r) begin
        dot_sum_r    <= '0;
        ref_energy_r <= '0;
        prb_energy_r <= '0;
      end else begin
        dot_sum_r    <= dot_nxt;
        ref_energy_r <= ref_nxt;
        prb_energy_r <= prb_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/csm_queue.sv =====
// ----------------------------------------------------------------------------
// csm_queue: vector sum queue
// Small FIFO of finished vector sums between the accumulator and the
// score engine.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_queue import csm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire csm_sums_t         push_data,
  input  wire logic              pop,
  output csm_sums_t              pop_data,
  output logic                   q_vld,
  output logic [QCNT_W-1:0]      q_cnt
);

  csm_sums_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign pop_data = mem_r[rd_ptr_r];
  assign q_vld    = (cnt_r != '0);
  assign q_cnt    = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  // Write entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < QCNT_W'(QDEPTH)) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== src/csm_back.sv =====
// ----------------------------------------------------------------------------
// csm_back: score engine
// Unless an energy is zero, forms the energy product and the squared dot sum
// on one shared multiplier, then finds the rounded score one bit per step
// with add/compare updates; in every case it loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_back import csm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_vld,
  input  wire csm_sums_t                q_data,
  output logic                          q_pop,
  input  wire logic signed [ELEM_W-1:0] match_threshold,
  csm_out_if.source                     out_chan
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Eight partial products: four for the energy product, four for dot^2
  localparam int MCNT_W = 4;
  localparam logic [MCNT_W-1:0] MUL_ISSUES = 4'd8;
  localparam logic [MCNT_W-1:0] MUL_INIT   = 4'd9;
  localparam int K_W = $clog2(QBITS);
  localparam logic [QBITS-1:0] SCORE_ONE = {1'b1, {(QBITS-1){1'b0}}};

  logic [1:0]               st_r;
  logic [1:0]               st_nxt;
  logic [ACC_W-1:0]         op_re_r;
  logic [ACC_W-1:0]         op_pe_r;
  logic [ACC_W-1:0]         mag_r;
  logic                     neg_r;
  logic                     zero_r;
  logic [MCNT_W-1:0]        mcnt_r;
  logic [2*HALF_W-1:0]      pp_r;
  logic [1:0]               pp_sh_r;
  logic                     pp_tgt_r;
  logic                     pp_vld_r;
  logic [PROD_W-1:0]        acc_p_r;
  logic [PROD_W-1:0]        acc_x_r;
  logic signed [SRCH_W-1:0] s_r;
  logic signed [SRCH_W-1:0] u_r;
  logic signed [SRCH_W-1:0] pk_r;
  logic signed [SRCH_W-1:0] cand_r;
  logic [QBITS-1:0]         q_r;
  logic [K_W-1:0]           k_r;
  logic                     phase_r;
  logic                     out_vld_r;
  logic [ELEM_W-1:0]        sim_r;
  logic                     match_r;

  logic                     q_zero;
  logic                     out_load;
  logic [2:0]               idx;
  logic [ACC_W-1:0]         a_op;
  logic [ACC_W-1:0]         b_op;
  logic [HALF_W-1:0]        a_half;
  logic [HALF_W-1:0]        b_half;
  logic [PROD_W-1:0]        pp_ext;
  logic signed [SRCH_W-1:0] p_wide;
  logic signed [SRCH_W-1:0] x_wide;
  logic                     q_sat;
  logic [ELEM_W-1:0]        score_w;
  logic                     match_w;

  assign q_zero   = (q_data.ref_energy == '0) || (q_data.prb_energy == '0);
  assign q_pop    = (st_r == ST_IDLE) && q_vld;
  assign out_load = (st_r == ST_DONE) && (!out_vld_r || out_chan.ready);

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_vld) st_nxt = q_zero ? ST_DONE : ST_MUL;
      ST_MUL:  if (mcnt_r == MUL_INIT) st_nxt = ST_SRCH;
      ST_SRCH: if (phase_r && (k_r == '0)) st_nxt = ST_DONE;
      ST_DONE: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Partial product operand selection
  always_comb begin
    idx    = mcnt_r[2:0];
    a_op   = idx[2] ? mag_r : op_re_r;
    b_op   = idx[2] ? mag_r : op_pe_r;
    a_half = idx[1] ? HALF_W'(a_op >> HALF_W) : a_op[HALF_W-1:0];
    b_half = idx[0] ? HALF_W'(b_op >> HALF_W) : b_op[HALF_W-1:0];
    case (pp_sh_r)
      2'd0:    pp_ext = PROD_W'(pp_r);
      2'd1:    pp_ext = PROD_W'(pp_r) << HALF_W;
      default: pp_ext = PROD_W'(pp_r) << (2 * HALF_W);
    endcase
  end

  assign p_wide = SRCH_W'(acc_p_r);
  assign x_wide = SRCH_W'(acc_x_r) << (2 * QBITS);

  // Load operands, run products, search score bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r   <= '0;
      pp_vld_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_vld) begin
            op_re_r  <= q_data.ref_energy;
            op_pe_r  <= q_data.prb_energy;
            mag_r    <= q_data.dot[ACC_W-1] ? ACC_W'(-q_data.dot) : q_data.dot;
            neg_r    <= q_data.dot[ACC_W-1];
            zero_r   <= q_zero;
            acc_p_r  <= '0;
            acc_x_r  <= '0;
            mcnt_r   <= '0;
            pp_vld_r <= 1'b0;
          end
        end
        ST_MUL: begin
          // Issue one partial product, fold in the previous one
          if (mcnt_r < MUL_ISSUES) begin
            pp_r     <= a_half * b_half;
            pp_sh_r  <= 2'(idx[1]) + 2'(idx[0]);
            pp_tgt_r <= idx[2];
            pp_vld_r <= 1'b1;
          end else begin
            pp_vld_r <= 1'b0;
          end
          if (pp_vld_r) begin
            if (pp_tgt_r) begin
              acc_x_r <= acc_x_r + pp_ext;
            end else begin
              acc_p_r <= acc_p_r + pp_ext;
            end
          end
          mcnt_r <= mcnt_r + 1'b1;
          // Start the search with q = 0: S = p, U = -p*2^(QBITS+1), P = p*2^(2*QBITS)
          if (mcnt_r == MUL_INIT) begin
            s_r     <= p_wide;
            u_r     <= -(p_wide <<< (QBITS + 1));
            pk_r    <= p_wide <<< (2 * QBITS);
            q_r     <= '0;
            k_r     <= K_W'(QBITS - 1);
            phase_r <= 1'b0;
          end
        end
        ST_SRCH: begin
          if (!phase_r) begin
            // Candidate (2q'-1)^2 * p for the trial bit
            cand_r <= s_r + u_r + pk_r;
          end else begin
            // Keep the bit if the candidate stays within 2^32 * dot^2
            if (cand_r <= x_wide) begin
              q_r[k_r] <= 1'b1;
              s_r      <= cand_r;
              u_r      <= (u_r + (pk_r <<< 1)) >>> 1;
            end else begin
              u_r <= u_r >>> 1;
            end
            pk_r <= pk_r >>> 2;
            k_r  <= k_r - 1'b1;
          end
          phase_r <= !phase_r;
        end
        ST_DONE: begin
          mcnt_r <= '0;
        end
        default: begin
          mcnt_r <= '0;
        end
      endcase
    end
  end

  // Apply the sign, saturate and compare
  always_comb begin
    q_sat = (q_r >= SCORE_ONE);
    if (zero_r) begin
      score_w = '0;
    end else if (neg_r) begin
      score_w = q_sat ? SCORE_MIN : ELEM_W'(-q_r);
    end else begin
      score_w = q_sat ? SCORE_MAX : ELEM_W'(q_r);
    end
    match_w = !zero_r && ($signed(score_w) > match_threshold);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      sim_r   <= score_w;
      match_r <= match_w;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.similarity = sim_r;
  assign out_chan.is_match   = match_r;

  a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL) |=> (st_r == ST_MUL) || (st_r == ST_SRCH))
    else $error("multiply phase left to an unexpected state");

  a_srch_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SRCH) |=> (st_r == ST_SRCH) || (st_r == ST_DONE))
    else $error("search phase left to an unexpected state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(st_r) == ST_DONE))
    else $error("result loaded outside the done state");

endmodule

`default_nettype wire

// ===== src/cosine_similarity_match.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_match: streaming cosine similarity matcher
// Accumulates element pairs of two vectors and reports their cosine
// similarity in Q1.15 together with a threshold match flag.
//
//   Channel   Dir  Transaction
//   in_chan   in   reference_element, probe_element, last_element
//   out_chan  out  similarity, is_match (one per vector)
//   APB       in   match_threshold at byte address 0
//
// The front end takes one element pair per cycle unless in_chan stalls.
// The score engine takes one vector at a time: it loads the sums, forms
// the products on the shared 20x20 multiplier, runs the 16-bit add/compare
// search, then loads the result; a zero-energy vector loads it directly.
// Two finished vectors can wait in the queue; beyond that in_chan stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_match import csm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  csm_in_if.sink                     in_chan,
  csm_out_if.source                  out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic signed [ELEM_W-1:0] thr_r;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic                     cfg_wr;
  logic                     push_vld;
  csm_sums_t                push_data;
  csm_sums_t                pop_data;
  logic                     q_pop;
  logic                     q_vld;
  logic [QCNT_W-1:0]        q_cnt;

  // Configuration register
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && (cfg_idx == REG_MATCH_THRESHOLD)) begin
      thr_r <= pwdata[ELEM_W-1:0];
    end
  end

  assign prdata = (cfg_idx == REG_MATCH_THRESHOLD) ? CFG_DATA_W'(thr_r) : '0;

  csm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_cnt     (q_cnt),
    .push_vld  (push_vld),
    .push_data (push_data)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_vld),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .q_vld     (q_vld),
    .q_cnt     (q_cnt)
  );

  csm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .match_threshold (thr_r),
    .out_chan        (out_chan)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cosine_similarity_match
// Streams element pairs into the matcher, predicts each vector's Q1.15
// cosine score and match flag with exact integer math, and compares every
// result transaction against the oldest prediction. Covers extreme
// elements, zero norms, score saturation, overlong vectors with saturating
// sums, threshold ties and sweeps over the APB port, and long output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import csm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int HOLDOFF_CYCLES = 400;
  // Time for two queued vectors to pass the score engine, plus margin
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PAIRS   = 100;
  localparam int REPORT_CAP     = 100;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 1'b1;

  localparam longint DOT_HI    = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint DOT_LO    = -(longint'(1) << (ACC_W - 1));
  localparam longint ENERGY_HI = (longint'(1) << ACC_W) - 1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] similarity;
    logic                     is_match;
  } score_t;

  typedef enum int {
    VEC_RANDOM,
    VEC_ALIGNED,
    VEC_OPPOSED,
    VEC_SPARSE,
    VEC_TINY
  } vec_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  csm_in_if  in_chan ();
  csm_out_if out_chan ();

  cosine_similarity_match i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: running sums and the threshold as the block should hold them
  longint                   dot_acc;
  longint                   ref_energy_acc;
  longint                   prb_energy_acc;
  logic signed [ELEM_W-1:0] match_thr;
  score_t                   expected_scores[$];

  int  error_count;
  int  pairs_sent;
  int  vectors_scored;
  int  thr_writes;
  int  quiet_cycles;
  int  hold_request;
  bit  src_idle_en;
  bit  sink_idle_en;

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(string what);
    if (error_count < REPORT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ELEM_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[ELEM_W-1:0];
  endfunction

  // Exact Q1.15 score: largest q with (2q-1)^2 * Er*Ep <= 2^32 * dot^2
  function automatic score_t cosine_score(longint dot, longint ref_en, longint prb_en,
                                          logic signed [ELEM_W-1:0] thr);
    bit [127:0]  mag;
    bit [127:0]  e_ref;
    bit [127:0]  e_prb;
    bit [127:0]  energy_prod;
    bit [127:0]  bound;
    bit [127:0]  odd;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int          s;
    score_t      r;
    r.similarity = '0;
    r.is_match   = 1'b0;
    if (ref_en == 0 || prb_en == 0) return r;
    mag         = (dot < 0) ? -dot : dot;
    e_ref       = ref_en;
    e_prb       = prb_en;
    energy_prod = e_ref * e_prb;
    bound       = (mag * mag) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      if (energy_prod * odd * odd <= bound) lo = mid;
      else hi = mid - 1;
    end
    if (dot < 0) s = -int'(lo);
    else s = (lo > 32767) ? 32767 : int'(lo);
    r.similarity = s[ELEM_W-1:0];
    r.is_match   = (s > int'(thr));
    return r;
  endfunction

  // Fold one accepted pair into the sums; close the vector on the last element
  function automatic void absorb_pair(logic signed [ELEM_W-1:0] ref_elem,
                                      logic signed [ELEM_W-1:0] prb_elem, logic last);
    longint a;
    longint b;
    a = ref_elem;
    b = prb_elem;
    dot_acc = dot_acc + a * b;
    if (dot_acc > DOT_HI) dot_acc = DOT_HI;
    if (dot_acc < DOT_LO) dot_acc = DOT_LO;
    ref_energy_acc = ref_energy_acc + a * a;
    if (ref_energy_acc > ENERGY_HI) ref_energy_acc = ENERGY_HI;
    prb_energy_acc = prb_energy_acc + b * b;
    if (prb_energy_acc > ENERGY_HI) prb_energy_acc = ENERGY_HI;
    if (last) begin
      expected_scores.push_back(cosine_score(dot_acc, ref_energy_acc, prb_energy_acc,
                                             match_thr));
      vectors_scored++;
      dot_acc        = 0;
      ref_energy_acc = 0;
      prb_energy_acc = 0;
    end
  endfunction

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      absorb_pair(in_chan.reference_element, in_chan.probe_element, in_chan.last_element);
    end
  end

  // Compare every result transaction against the oldest prediction
  always @(posedge clk) begin : check_scores
    score_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: similarity %0d match %0b",
                                  out_chan.similarity, out_chan.is_match));
      end else begin
        want = expected_scores.pop_front();
        if (out_chan.similarity !== want.similarity) begin
          report_mismatch($sformatf("similarity %0d, expected %0d",
                                    out_chan.similarity, want.similarity));
        end
        if (out_chan.is_match !== want.is_match) begin
          report_mismatch($sformatf("is_match %0b, expected %0b (similarity %0d)",
                                    out_chan.is_match, want.is_match, want.similarity));
        end
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    out_chan.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_scores.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one element pair after an optional gap and hold it until accepted
  task automatic send_pair(logic signed [ELEM_W-1:0] ref_elem,
                           logic signed [ELEM_W-1:0] prb_elem, logic last);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid             = 1'b0;
      in_chan.reference_element = ELEM_W'($urandom);
      in_chan.probe_element     = ELEM_W'($urandom);
      in_chan.last_element      = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid             = 1'b1;
    in_chan.reference_element = ref_elem;
    in_chan.probe_element     = prb_elem;
    in_chan.last_element      = last;
    do @(posedge clk); while (!in_chan.ready);
    pairs_sent++;
  endtask

  task automatic send_run(logic signed [ELEM_W-1:0] ref_elem,
                          logic signed [ELEM_W-1:0] prb_elem, int count, bit close);
    for (int i = 0; i < count; i++) begin
      send_pair(ref_elem, prb_elem, close && (i == count - 1));
    end
  endtask

  function automatic int vector_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 88) return $urandom_range(9, 40);
    if (r < 97) return $urandom_range(41, 128);
    return $urandom_range(129, VECTOR_LENGTH);
  endfunction

  function automatic int noise_amp();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 8;
      2:       return 300;
      3:       return 4000;
      default: return 20000;
    endcase
  endfunction

  // Send one whole vector whose probe relates to the reference as the style says
  task automatic send_vector(int len, vec_style_t style, int amp);
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    int                       jitter;
    for (int i = 0; i < len; i++) begin
      a      = ELEM_W'($urandom);
      b      = ELEM_W'($urandom);
      jitter = int'($urandom_range(0, 2 * amp)) - amp;
      case (style)
        VEC_ALIGNED: b = clamp16(int'(a) + jitter);
        VEC_OPPOSED: b = clamp16(-int'(a) + jitter);
        VEC_SPARSE: begin
          if ($urandom_range(0, 2) == 0) a = '0;
          if ($urandom_range(0, 2) == 0) b = '0;
        end
        VEC_TINY: begin
          a = ELEM_W'($urandom_range(0, 8) - 4);
          b = ELEM_W'($urandom_range(0, 8) - 4);
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Drop valid, wait for every outstanding score, then let the back end drain
  task automatic wait_block_idle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MATCH_THRESHOLD) begin
      match_thr = data[ELEM_W-1:0];
      thr_writes++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic cfg_read(logic [CFG_IDX_W-1:0] idx, output logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_threshold_readback();
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(REG_MATCH_THRESHOLD, rd);
    if (rd[ELEM_W-1:0] !== match_thr) begin
      report_mismatch($sformatf("threshold reads %0d, expected %0d",
                                $signed(rd[ELEM_W-1:0]), match_thr));
    end
  endtask

  // Change the threshold while idle; junk in the upper bits must be ignored
  task automatic set_threshold(logic signed [ELEM_W-1:0] thr, bit poke_unused);
    logic [CFG_DATA_W-1:0] data;
    wait_block_idle();
    data                = $urandom;
    data[ELEM_W-1:0]    = thr;
    cfg_write(REG_MATCH_THRESHOLD, data);
    if (poke_unused) cfg_write(REG_UNUSED, $urandom);
    check_threshold_readback();
  endtask

  // Extreme elements, zero norms, orthogonal and rounding cases at reset threshold
  task automatic test_directed_vectors();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    check_threshold_readback();
    send_pair(32767, 32767, 1'b1);
    send_pair(-32768, -32768, 1'b1);
    send_pair(-32768, 32767, 1'b1);
    send_pair(32767, -32768, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(0, -32768, 1'b1);
    send_pair(32767, 0, 1'b1);
    send_pair(1, 0, 1'b0);
    send_pair(0, 1, 1'b1);
    send_pair(1, 1, 1'b0);
    send_pair(1, -1, 1'b1);
    send_pair(-1, 1, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b0);
    send_pair(16'shaaaa, 16'sh5555, 1'b0);
    send_pair(32767, 1, 1'b1);
    send_pair(3, 4, 1'b0);
    send_pair(4, 3, 1'b1);
    send_pair(1, 2, 1'b0);
    send_pair(2, 1, 1'b1);
    src_idle_en = 1'b1;
    send_pair(-2, 3, 1'b0);
    send_pair(7, -5, 1'b1);
  endtask

  // Sweep thresholds incl. both extremes; identical and negated vectors hit the ties
  task automatic test_threshold_sweep();
    logic signed [ELEM_W-1:0] sweep [7] = '{-32768, 32767, 0, -1, 1, 29000, -20000};
    sink_idle_en = 1'b1;
    foreach (sweep[k]) begin
      set_threshold(sweep[k], k < 3);
      send_vector($urandom_range(1, 6), VEC_ALIGNED, 0);
      send_vector($urandom_range(1, 6), VEC_OPPOSED, 0);
      send_vector($urandom_range(2, 12), VEC_ALIGNED, noise_amp());
      send_vector($urandom_range(1, 12), VEC_RANDOM, 0);
    end
    set_threshold(THR_RESET, 1'b0);
  endtask

  // Overlong vectors drive all three sums into saturation, and back out of it
  task automatic test_overlong_vectors();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_run(-32768, -32768, 516, 1'b0);
    send_run(-32768, 32767, 514, 1'b1);
    send_run(-32768, 32767, 516, 1'b1);
  endtask

  // Hold the sink off long enough that the queue fills and in_chan stalls
  task automatic test_output_holdoff();
    wait_block_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_request = HOLDOFF_CYCLES;
    repeat (6) send_vector(4, VEC_RANDOM, 0);
    wait_block_idle();
  endtask

  // Mixed random vectors with occasional threshold changes between them
  task automatic test_random_stream();
    int                       start;
    logic signed [ELEM_W-1:0] thr;
    start = pairs_sent;
    while (pairs_sent - start < RANDOM_PAIRS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 7)) inside
          0:       thr = -32768;
          1:       thr = 32767;
          [2:3]:   thr = ELEM_W'($urandom_range(20000, 32767));
          default: thr = ELEM_W'($urandom);
        endcase
        set_threshold(thr, $urandom_range(0, 3) == 0);
      end
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      send_vector(vector_len(), vec_style_t'($urandom_range(0, int'(VEC_TINY))), noise_amp());
    end
  endtask

  initial begin
    rst_n                     = 1'b0;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    in_chan.valid             = 1'b0;
    in_chan.reference_element = '0;
    in_chan.probe_element     = '0;
    in_chan.last_element      = 1'b0;
    dot_acc                   = 0;
    ref_energy_acc            = 0;
    prb_energy_acc            = 0;
    match_thr                 = THR_RESET;
    error_count               = 0;
    pairs_sent                = 0;
    vectors_scored            = 0;
    thr_writes                = 0;
    quiet_cycles              = 0;
    hold_request              = 0;
    src_idle_en               = 1'b0;
    sink_idle_en              = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_vectors();
    test_threshold_sweep();
    test_overlong_vectors();
    test_output_holdoff();
    test_random_stream();
    wait_block_idle();

    $display("Covered %0d vectors from %0d element pairs with %0d threshold writes,",
             vectors_scored, pairs_sent, thr_writes);
    $display("including saturating sums, zero norms and a %0d-cycle output hold-off.",
             HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
